@@ design/eks_pkg.sv @@
// Shared types and constants for the Epanechnikov kernel smoother.
package eks_pkg;

  localparam int BIN_W       = 16;
  localparam int OUT_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BIN_W-1:0] bin_value;
    logic             last;
  } item_t;

endpackage

@@ design/eks_bin_if.sv @@
// Input request channel: histogram bins with end-of-stream mark.
interface eks_bin_if;
  import eks_pkg::*;

  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin_value;
  logic             stream_end;

  modport source (output valid, output bin_value, output stream_end, input ready);
  modport sink   (input valid, input bin_value, input stream_end, output ready);
endinterface

@@ design/eks_smooth_if.sv @@
// Output request channel: smoothed bins with final-result mark.
interface eks_smooth_if;
  import eks_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] smoothed_value;
  logic             last_out;

  modport source (output valid, output smoothed_value, output last_out, input ready);
  modport sink   (input valid, input smoothed_value, input last_out, output ready);
endinterface

@@ design/eks_front.sv @@
// Front end: accepts bins and expands a stream end into flush requests.
module eks_front #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  eks_bin_if.sink       bin_stream,
  input  logic          q_full,
  output logic          push,
  output eks_pkg::item_t push_item,
  output logic          flushing
);
  import eks_pkg::*;

  localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(DEPTH - 1);

  localparam logic ST_PASS  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic          state;
  logic          state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    push              = 1'b0;
    bin_stream.ready  = 1'b0;
    push_item.bin_value = bin_stream.bin_value;
    push_item.last    = 1'b0;
    unique case (state)
      ST_PASS: begin
        bin_stream.ready = !q_full;
        if (bin_stream.valid && !q_full) begin
          push = 1'b1;
          if (bin_stream.stream_end) begin
            state_next = ST_FLUSH;
            cnt_next   = '0;
          end
        end
      end
      ST_FLUSH: begin
        push_item.bin_value = '0;
        push_item.last      = (cnt == LAST_CNT);
        if (!q_full) begin
          push     = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == LAST_CNT) begin
            state_next = ST_PASS;
          end
        end
      end
      default: begin
        state_next = ST_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PASS;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign flushing = (state == ST_FLUSH);

endmodule

@@ design/eks_queue.sv @@
// Short request queue between the front end and the filter back end.
module eks_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  eks_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output eks_pkg::item_t pop_item,
  output logic           empty
);
  import eks_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/eks_back.sv @@
// Back end: transposed kernel filter, reciprocal-multiply rounding divide, output register.
module eks_back #(
  parameter int HALF_WIDTH = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  eks_pkg::item_t pop_item,
  input  logic           q_empty,
  output logic           pop,
  eks_smooth_if.source   smooth_stream
);
  import eks_pkg::*;

  localparam int DEPTH     = 2 * HALF_WIDTH;
  localparam int NORM      = HALF_WIDTH * (4 * HALF_WIDTH * HALF_WIDTH - 1) / 3;
  localparam int HALF_NORM = NORM / 2;
  localparam int EW        = (VALUE_BITS < BIN_W) ? VALUE_BITS : BIN_W;
  localparam int RW        = $clog2(NORM + 1);
  localparam int SW        = EW + RW;
  localparam int SHIFT     = SW + $clog2(NORM);
  localparam int PW        = 2 * SW + 1;
  localparam longint unsigned RECIP_64 =
    ((64'd1 << SHIFT) + 64'(NORM) - 64'd1) / 64'(NORM);
  localparam logic [SW:0] RECIP = (SW + 1)'(RECIP_64);

  logic          adv;
  logic [EW-1:0] x_m;
  logic [SW-1:0] acc [1:DEPTH-1];
  logic [SW-1:0] num;

  logic          sum_vld;
  logic          sum_last;
  logic [SW-1:0] sum_r;
  logic          prod_vld;
  logic          prod_last;
  logic [PW-1:0] prod_r;

  assign adv = !smooth_stream.valid || smooth_stream.ready;
  assign pop = !q_empty && adv;
  assign x_m = pop_item.bin_value[EW-1:0];

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    localparam logic [SW-1:0] WK = SW'(k * (DEPTH - k));
    if (k == DEPTH - 1) begin : g_end
      always_ff @(posedge clk) begin
        if (rst) begin
          acc[k] <= '0;
        end else if (pop) begin
          acc[k] <= SW'(x_m) * WK;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (rst) begin
          acc[k] <= '0;
        end else if (pop) begin
          acc[k] <= acc[k+1] + SW'(x_m) * WK;
        end
      end
    end
  end

  assign num = acc[1] + SW'(HALF_NORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld  <= 1'b0;
      prod_vld <= 1'b0;
    end else if (adv) begin
      sum_vld  <= pop;
      prod_vld <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r     <= num;
      sum_last  <= pop_item.last;
      prod_r    <= PW'(sum_r) * PW'(RECIP);
      prod_last <= sum_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_stream.valid <= 1'b0;
    end else if (adv) begin
      smooth_stream.valid <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smooth_stream.smoothed_value <= OUT_W'(prod_r[SHIFT +: EW]);
      smooth_stream.last_out       <= prod_last;
    end
  end

endmodule

@@ design/epanechnikov_kernel_smoother_unit.sv @@
// Top level of the Epanechnikov kernel smoother.
//
//   channel        dir  payload                          handshake
//   bin_stream     in   bin_value[15:0], stream_end      valid/ready
//   smooth_stream  out  smoothed_value[15:0], last_out   valid/ready
//
// One bin per cycle while the queue has room; one result per bin, a stream_end bin adds
// 2*HALF_WIDTH flush results and holds bin_stream.ready low while they enter.
// A result is valid once its bin has passed through the queue, sum register,
// reciprocal product and output register.
// Reset clears the filter chain, queue and valid bits.
// A stalled output freezes the back pipeline; the 4-entry queue absorbs the front.
module epanechnikov_kernel_smoother_unit #(
  parameter int HALF_WIDTH = 8,
  parameter int VALUE_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  eks_bin_if.sink      bin_stream,
  eks_smooth_if.source smooth_stream
);
  import eks_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  logic  flushing;
  item_t push_item;
  item_t pop_item;

  eks_front #(
    .DEPTH(2 * HALF_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bin_stream(bin_stream),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .flushing  (flushing)
  );

  eks_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .pop_item (pop_item),
    .empty    (q_empty)
  );

  eks_back #(
    .HALF_WIDTH(HALF_WIDTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_item     (pop_item),
    .q_empty      (q_empty),
    .pop          (pop),
    .smooth_stream(smooth_stream)
  );

`ifndef SYNTH
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !bin_stream.ready)
    else $error("bin accepted during flush");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue underflow");
`endif

endmodule

@@ verif/tb_epanechnikov_kernel_smoother_unit.sv @@
// Testbench for the Epanechnikov kernel smoother: random bin streams checked against a predictor.
module tb_epanechnikov_kernel_smoother_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import eks_pkg::*;

  localparam int K         = 8;
  localparam int VB        = 16;
  localparam int DEPTH     = 2 * K;
  localparam int NORM      = K * (4 * K * K - 1) / 3;
  localparam int TOTAL     = 270;
  localparam int HOLD      = 160;
  localparam int DRAIN     = 40;
  localparam int LIMIT     = 200000;

  typedef longint unsigned u64_t;

  class smoother_scoreboard;
    typedef struct {
      logic [OUT_W-1:0] value;
      logic             last;
    } smooth_t;

    logic [BIN_W-1:0] history[DEPTH];
    smooth_t          expected[$];
    int unsigned      failures;
    int unsigned      results_seen;

    function new();
      clear_history();
      failures     = 0;
      results_seen = 0;
    endfunction

    function void clear_history();
      foreach (history[i]) history[i] = '0;
    endfunction

    function logic [OUT_W-1:0] smooth_push(logic [BIN_W-1:0] bin);
      u64_t acc = 0;
      for (int d = 1; d <= DEPTH; d++)
        acc += u64_t'(d * (DEPTH - d)) * u64_t'(history[d-1]);
      for (int d = DEPTH - 1; d > 0; d--)
        history[d] = history[d-1];
      history[0] = bin;
      return OUT_W'((acc + u64_t'(NORM / 2)) / u64_t'(NORM));
    endfunction

    function void note_bin(logic [BIN_W-1:0] bin, logic stream_end);
      smooth_t e;
      e.value = smooth_push(bin);
      e.last  = 1'b0;
      expected.insert(expected.size(), e);
      if (stream_end) begin
        for (int k = 1; k <= DEPTH; k++) begin
          e.value = smooth_push('0);
          e.last  = (k == DEPTH);
          expected.insert(expected.size(), e);
        end
        clear_history();
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] value, logic last);
      smooth_t e;
      results_seen++;
      if (expected.size() == 0) begin
        $error("smoothed_value: expected nothing, got %0h (last_out %0b)", value, last);
        failures++;
        return;
      end
      e = expected.pop_front();
      if (value !== e.value) begin
        $error("smoothed_value: expected %0h, got %0h", e.value, value);
        failures++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %0b, got %0b", e.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  eks_bin_if    bin_stream();
  eks_smooth_if smooth_stream();

  epanechnikov_kernel_smoother_unit #(
    .HALF_WIDTH(K),
    .VALUE_BITS(VB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .bin_stream   (bin_stream),
    .smooth_stream(smooth_stream)
  );

  smoother_scoreboard sb;
  bit                 quiet = 1'b0;
  int                 bins_sent = 0;
  int unsigned        cycles = 0;

  always #6 clk = ~clk;

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic logic [BIN_W-1:0] random_bin();
    case ($urandom_range(0, 7)) inside
      0:       return '0;
      1:       return '1;
      2:       return BIN_W'($urandom_range(0, 255));
      [3:4]:   return BIN_W'($urandom_range(0, 4096));
      default: return BIN_W'($urandom);
    endcase
  endfunction

  task automatic send_bin(input logic [BIN_W-1:0] value, input logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      bin_stream.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bin_stream.valid      <= 1'b1;
    bin_stream.bin_value  <= value;
    bin_stream.stream_end <= last;
    do @(posedge clk); while (!bin_stream.ready);
    bins_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    bin_stream.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (bin_stream.valid && bin_stream.ready)
        sb.note_bin(bin_stream.bin_value, bin_stream.stream_end);
      if (smooth_stream.valid && smooth_stream.ready)
        sb.check_result(smooth_stream.smoothed_value, smooth_stream.last_out);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_epanechnikov_kernel_smoother_unit: done, errors");
      $finish;
    end
  end

  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    smooth_stream.ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (!held && sb.results_seen >= 200) begin
        held  = 1'b1;
        stall = HOLD;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        smooth_stream.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      smooth_stream.ready <= 1'b1;
      do @(posedge clk); while (!smooth_stream.valid);
      @(negedge clk);
    end
  end

  initial begin
    int  len;
    bit  paused;
    sb     = new();
    paused = 1'b0;
    rst                   = 1'b1;
    bin_stream.valid      = 1'b0;
    bin_stream.bin_value  = '0;
    bin_stream.stream_end = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-bin stream, a full window of maximum bins, then a stream of edge-case values
    send_bin('1, 1'b1);
    for (int i = 0; i < DEPTH; i++)
      send_bin('1, i == DEPTH - 1);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'h7FFF, 1'b0);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h5555, 1'b0);
    send_bin(16'h0000, 1'b1);
    drain_results();

    while (bins_sent < TOTAL) begin
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 30);
      quiet = (bins_sent >= 60 && bins_sent < 100);
      if (!paused && bins_sent >= 160) begin
        paused = 1'b1;
        drain_results();
      end
      for (int i = 0; i < len; i++)
        send_bin(random_bin(), i == len - 1);
    end
    quiet = 1'b0;

    drain_results();
    repeat (DRAIN) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_epanechnikov_kernel_smoother_unit: done, clean");
    end else begin
      $display("tb_epanechnikov_kernel_smoother_unit: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/eks_pkg.sv
design/eks_bin_if.sv
design/eks_smooth_if.sv
design/eks_front.sv
design/eks_queue.sv
design/eks_back.sv
design/epanechnikov_kernel_smoother_unit.sv
verif/tb_epanechnikov_kernel_smoother_unit.sv
